// ----- src/bpl_pkg.sv -----
// ----------------------------------------------------------------------------
// bpl_pkg: shared types and codes of the buffer pool pin manager
// Command, status and scan structs passed between the sequencer and the cells.
// ----------------------------------------------------------------------------
`default_nettype none
package bpl_pkg;

  localparam int unsigned DefFrames = 16;
  localparam int unsigned MaxW      = 6;   // slot / rank width for up to 64 frames
  localparam logic [31:0] InvPage   = 32'hFFFF_FFFF;
  localparam logic [15:0] PinMax    = 16'hFFFF;

  typedef enum logic [2:0] {
    K_FETCH = 3'd0, K_UNPIN = 3'd1, K_NEW = 3'd2, K_FLUSH = 3'd3, K_FLALL = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0, ST_MISS = 3'd1, ST_NEWP = 3'd2, ST_NOTF = 3'd3, ST_ALLPIN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0, OP_READ = 3'd1, OP_WRITE = 3'd2, OP_ZERO = 3'd3, OP_SYNC = 3'd4
  } disk_op_e;

  typedef enum logic [2:0] {
    C_NONE = 3'd0, C_PIN_INC = 3'd1, C_PIN_DEC = 3'd2, C_CLR_DIRTY = 3'd3, C_PLACE = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [MaxW-1:0]   slot;
    logic [31:0]       page;
    logic              md;
    logic              touch;
    logic [MaxW-1:0]   trank;
  } cell_cmd_t;

  typedef struct packed {
    logic [31:0]     page;
    logic            dirty;
    logic [15:0]     pins;
    logic [MaxW-1:0] rank;
    logic            hit;
  } cell_st_t;

  typedef struct packed {
    logic            valid;
    logic [MaxW-1:0] slot;
    logic [MaxW-1:0] rank;
  } scan_t;

endpackage
`default_nettype wire

// ----- src/bpl_if.sv -----
// ----------------------------------------------------------------------------
// bpl_in_if / bpl_out_if: request and result channels
// Valid/ready channels; a transaction moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none
interface bpl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] page_id;
  logic        mark_dirty;
  modport source (output valid, kind, page_id, mark_dirty, input ready);
  modport sink   (input valid, kind, page_id, mark_dirty, output ready);
endinterface

interface bpl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  frame_slot;
  logic [2:0]  disk_op;
  logic [31:0] disk_page;
  logic        last;
  modport source (output valid, status, frame_slot, disk_op, disk_page, last, input ready);
  modport sink   (input valid, status, frame_slot, disk_op, disk_page, last, output ready);
endinterface
`default_nettype wire

// ----- src/buffer_pool_lru_pin_manager_core.sv -----
// ----------------------------------------------------------------------------
// buffer_pool_lru_pin_manager_core: buffer pool frame manager, LRU + pins
// Sequencer over a chain of frame cells; emits disk operation transactions.
// ----------------------------------------------------------------------------
// Hit, unpin, flush page and rejects: the result is registered once the look-up
//   state sees the output register free; miss or new page: a victim scan (one
//   chain cell per cycle), then any write-back leading the final result.
// Flush all walks the frames one per cycle unless a write-back waits on the output.
// One request at a time; the next is taken once the sequencer is idle, even
//   while the last result still sits in the output register.
// Reset: async, active low; frames invalid, clean, unpinned, rank = slot.
`default_nettype none
module buffer_pool_lru_pin_manager_core import bpl_pkg::*; #(
  parameter int unsigned FRAMES = DefFrames
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpl_in_if.sink    in_if,
  bpl_out_if.source out_if
);
  localparam int unsigned SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_WB    = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_SYNC  = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [2:0]    kind_q;
  logic [31:0]   pid_q;
  logic          md_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] vic_q, vic_d;

  // output register
  logic          ov_q;
  logic [2:0]    ost_q, oop_q;
  logic [SW-1:0] oslot_q;
  logic [31:0]   opage_q;
  logic          olast_q;

  // emit request from the sequencer
  logic          emit;
  status_e       e_st;
  disk_op_e      e_op;
  logic [SW-1:0] e_slot;
  logic [31:0]   e_page;
  logic          e_last;

  cell_cmd_t     cmd;
  cell_st_t      cst [FRAMES];
  scan_t         chain [FRAMES+1];
  cell_st_t      sel_st;
  logic [SW-1:0] sel_slot, hit_slot;
  logic          hit_any, out_free;

  assign chain[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    bpl_cell #(.IDX(g), .SW(SW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .look_page_i (pid_q),
      .scan_i      (chain[g]),
      .scan_o      (chain[g+1]),
      .st_o        (cst[g])
    );
  end

  // at most one cell matches; encode by OR over the indices
  always_comb begin
    hit_any  = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (cst[i].hit) begin
        hit_any  = 1'b1;
        hit_slot = hit_slot | SW'(i);
      end
    end
  end

  always_comb begin
    if (state_q == S_LOOK)       sel_slot = hit_slot;
    else if (state_q == S_FLUSH) sel_slot = cnt_q[SW-1:0];
    else                         sel_slot = vic_q;
  end
  assign sel_st   = cst[sel_slot];
  assign out_free = !ov_q || out_if.ready;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    vic_d   = vic_q;
    emit    = 1'b0;
    e_st    = ST_NOTF;
    e_op    = OP_NONE;
    e_slot  = '0;
    e_page  = pid_q;
    e_last  = 1'b1;
    cmd       = '0;
    cmd.op    = C_NONE;
    cmd.slot  = MaxW'(sel_slot);
    cmd.page  = pid_q;
    cmd.md    = md_q;
    cmd.trank = sel_st.rank;
    case (state_q)
      S_IDLE: if (in_if.valid) state_d = S_LOOK;
      S_LOOK: begin
        if (out_free) begin
          state_d = S_IDLE;
          emit    = 1'b1;
          case (kind_q)
            K_FETCH: begin
              if (hit_any) begin
                e_st      = ST_DONE;
                e_slot    = hit_slot;
                cmd.op    = C_PIN_INC;
                cmd.touch = 1'b1;
              end else if (pid_q != InvPage) begin
                emit    = 1'b0;
                state_d = S_SCAN;
                cnt_d   = '0;
              end
            end
            K_UNPIN: begin
              if (hit_any) begin
                e_slot = hit_slot;
                if (sel_st.pins != 16'd0) begin
                  e_st   = ST_DONE;
                  cmd.op = C_PIN_DEC;
                end
              end
            end
            K_NEW: begin
              if (hit_any) e_slot = hit_slot;
              else if (pid_q != InvPage) begin
                emit    = 1'b0;
                state_d = S_SCAN;
                cnt_d   = '0;
              end
            end
            K_FLUSH: begin
              if (hit_any) begin
                e_st   = ST_DONE;
                e_slot = hit_slot;
                if (sel_st.dirty) begin
                  e_op   = OP_WRITE;
                  cmd.op = C_CLR_DIRTY;
                end
              end
            end
            K_FLALL: begin
              emit    = 1'b0;
              state_d = S_FLUSH;
              cnt_d   = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // chain output is settled once the scan has passed every registered cell
        if (cnt_q != CW'(FRAMES)) cnt_d = cnt_q + CW'(1);
        else if (!chain[FRAMES].valid) begin
          if (out_free) begin
            emit    = 1'b1;
            e_st    = ST_ALLPIN;
            state_d = S_IDLE;
          end
        end else begin
          vic_d   = chain[FRAMES].slot[SW-1:0];
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (sel_st.page == InvPage || !sel_st.dirty) state_d = S_FIN;
        else if (out_free) begin
          emit    = 1'b1;
          e_st    = (kind_q == K_NEW) ? ST_NEWP : ST_MISS;
          e_op    = OP_WRITE;
          e_slot  = vic_q;
          e_page  = sel_st.page;
          e_last  = 1'b0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          e_st      = (kind_q == K_NEW) ? ST_NEWP : ST_MISS;
          e_op      = (kind_q == K_NEW) ? OP_ZERO : OP_READ;
          e_slot    = vic_q;
          cmd.op    = C_PLACE;
          cmd.touch = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sel_st.page != InvPage && sel_st.dirty) begin
          if (out_free) begin
            emit   = 1'b1;
            e_st   = ST_DONE;
            e_op   = OP_WRITE;
            e_slot = sel_slot;
            e_page = sel_st.page;
            e_last = 1'b0;
            cmd.op = C_CLR_DIRTY;
            if (cnt_q == CW'(FRAMES - 1)) state_d = S_SYNC;
            else cnt_d = cnt_q + CW'(1);
          end
        end else if (cnt_q == CW'(FRAMES - 1)) state_d = S_SYNC;
        else cnt_d = cnt_q + CW'(1);
      end
      S_SYNC: begin
        if (out_free) begin
          emit    = 1'b1;
          e_st    = ST_DONE;
          e_op    = OP_SYNC;
          e_page  = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_if.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      vic_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vic_q   <= vic_d;
      if (emit)              ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      kind_q <= in_if.kind;
      pid_q  <= in_if.page_id;
      md_q   <= in_if.mark_dirty;
    end
    if (emit) begin
      ost_q   <= e_st;
      oop_q   <= e_op;
      oslot_q <= e_slot;
      opage_q <= e_page;
      olast_q <= e_last;
    end
  end

  logic [SW+3:0] slot_ext;
  assign slot_ext = {4'b0, oslot_q};

  assign out_if.valid      = ov_q;
  assign out_if.status     = ost_q;
  assign out_if.frame_slot = slot_ext[3:0];
  assign out_if.disk_op    = oop_q;
  assign out_if.disk_page  = opage_q;
  assign out_if.last       = olast_q;
endmodule
`default_nettype wire

// ----- src/bpl_cell.sv -----
// ----------------------------------------------------------------------------
// bpl_cell: one buffer frame
// Holds page, dirty, pins and rank; runs one step of the victim scan chain.
// ----------------------------------------------------------------------------
`default_nettype none
module bpl_cell import bpl_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_cmd_t cmd_i,
  input  wire logic [31:0] look_page_i,
  input  wire scan_t     scan_i,
  output scan_t          scan_o,
  output cell_st_t       st_o
);
  logic [31:0]   page_q, page_d;
  logic          dirty_q, dirty_d;
  logic [15:0]   pins_q, pins_d;
  logic [SW-1:0] rank_q, rank_d;
  scan_t         scan_q, scan_d;
  logic          sel;
  logic [SW-1:0] trank;

  assign sel   = (cmd_i.slot == MaxW'(IDX));
  assign trank = cmd_i.trank[SW-1:0];

  always_comb begin
    page_d  = page_q;
    dirty_d = dirty_q;
    pins_d  = pins_q;
    rank_d  = rank_q;
    if (sel) begin
      case (cmd_i.op)
        C_PIN_INC:   if (pins_q != PinMax) pins_d = pins_q + 16'd1;
        C_PIN_DEC: begin
          pins_d = pins_q - 16'd1;
          if (cmd_i.md) dirty_d = 1'b1;
        end
        C_CLR_DIRTY: dirty_d = 1'b0;
        C_PLACE: begin
          page_d  = cmd_i.page;
          dirty_d = 1'b0;
          pins_d  = 16'd1;
        end
        default: ;
      endcase
    end
    if (cmd_i.touch) begin
      if (sel) rank_d = '0;
      else if (rank_q < trank) rank_d = rank_q + SW'(1);
    end
  end

  // victim scan: keep the least recent unpinned frame seen so far
  always_comb begin
    scan_d = scan_i;
    if (pins_q == 16'd0 && (!scan_i.valid || MaxW'(rank_q) > scan_i.rank)) begin
      scan_d.valid = 1'b1;
      scan_d.slot  = MaxW'(IDX);
      scan_d.rank  = MaxW'(rank_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= InvPage;
      dirty_q <= 1'b0;
      pins_q  <= '0;
      rank_q  <= SW'(IDX);
      scan_q  <= '0;
    end else begin
      page_q  <= page_d;
      dirty_q <= dirty_d;
      pins_q  <= pins_d;
      rank_q  <= rank_d;
      scan_q  <= scan_d;
    end
  end

  assign scan_o   = scan_q;
  assign st_o.page  = page_q;
  assign st_o.dirty = dirty_q;
  assign st_o.pins  = pins_q;
  assign st_o.rank  = MaxW'(rank_q);
  assign st_o.hit   = (look_page_i != InvPage) && (page_q == look_page_i);
endmodule
`default_nettype wire

// ----- src/bpl_checker.sv -----
// ----------------------------------------------------------------------------
// bpl_checker: port level checks of the pin manager
// Result framing and request pacing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bpl_checker import bpl_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [3:0]  out_slot,
  input wire logic [2:0]  out_op,
  input wire logic [31:0] out_page,
  input wire logic        out_last
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_page) && $stable(out_last))
    else $error("stalled result changed");

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_op == OP_SYNC |-> out_last && out_slot == 4'd0 && out_page == 32'd0)
    else $error("malformed sync transaction");

  a_allpin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status == ST_ALLPIN |-> out_last && out_op == OP_NONE)
    else $error("malformed all-pinned transaction");
endmodule

bind buffer_pool_lru_pin_manager_core bpl_checker u_bpl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_slot   (out_if.frame_slot),
  .out_op     (out_if.disk_op),
  .out_page   (out_if.disk_page),
  .out_last   (out_if.last)
);
`default_nettype wire
